// ===== rtl/pqt_pkg.sv =====
// Shared types and constants for the planar heading to quaternion block.
`timescale 1ns / 1ps
package pqt_pkg;

   localparam int ANGLE_TABLE_LEN = 24;

   // Datapath widths of the two CORDIC chains.
   localparam int VEC_W = 34;
   localparam int ROT_W = 33;

   // atan(2^-i) in a 32-bit binary angle (2^32 is a full turn).
   localparam logic [31:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Start vector of the rotation, 2^30 divided by the CORDIC gain.
   localparam logic signed [ROT_W-1:0] CORDIC_X0 = 33'sd652032874;

   // Headings on the axes.
   localparam logic [15:0] HEAD_EAST  = 16'd0;
   localparam logic [15:0] HEAD_NORTH = 16'd16384;
   localparam logic [15:0] HEAD_WEST  = 16'd32768;
   localparam logic [15:0] HEAD_SOUTH = 16'd49152;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pos_type;

   typedef struct packed {
      logic                    special;
      logic [15:0]             fixed_head;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [31:0]             z;
   } vec_type;

   typedef struct packed {
      logic                    upper;
      logic [15:0]             head;
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
   } rot_type;

   typedef struct packed {
      pos_type            pos;
      logic [15:0]        head;
      logic [14:0]        qz;
      logic signed [15:0] qw;
   } out_type;

endpackage

// ===== rtl/pqt_req_if.sv =====
// Request channel: centre point and axis tip.
`timescale 1ns / 1ps
interface pqt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic signed [31:0] axis_tip_x;
   logic signed [31:0] axis_tip_y;

   modport source (
      output valid, center_x, center_y, center_z, axis_tip_x, axis_tip_y,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, center_z, axis_tip_x, axis_tip_y,
      output ready
   );
endinterface

// ===== rtl/pqt_rsp_if.sv =====
// Response channel: position, heading and z-axis quaternion.
`timescale 1ns / 1ps
interface pqt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [15:0]        heading;
   logic [14:0]        quat_z_part;
   logic signed [15:0] quat_w_part;

   modport source (
      output valid, pos_x, pos_y, pos_z, heading, quat_z_part, quat_w_part,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, heading, quat_z_part, quat_w_part,
      output ready
   );
endinterface

// ===== rtl/pqt_vec_stage.sv =====
// One registered vectoring CORDIC iteration.
`timescale 1ns / 1ps
module pqt_vec_stage import pqt_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    en,
   input  vec_type src,
   output vec_type vec_ff
);

   localparam logic [31:0] ATAN = ATAN_TABLE[STEP];

   vec_type vec_in;

   // Drive y toward zero; the angle accumulator wraps modulo a full turn.
   always_comb begin
      vec_in = src;
      if (src.y > 0) begin
         vec_in.x = src.x + (src.y >>> STEP);
         vec_in.y = src.y - (src.x >>> STEP);
         vec_in.z = src.z + ATAN;
      end else begin
         vec_in.x = src.x - (src.y >>> STEP);
         vec_in.y = src.y + (src.x >>> STEP);
         vec_in.z = src.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// ===== rtl/pqt_rot_stage.sv =====
// One registered rotating CORDIC iteration.
`timescale 1ns / 1ps
module pqt_rot_stage import pqt_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    en,
   input  rot_type src,
   output rot_type rot_ff
);

   localparam logic signed [ROT_W-1:0] ATAN = $signed({1'b0, ATAN_TABLE[STEP]});

   rot_type rot_in;

   always_comb begin
      rot_in = src;
      if (src.z >= 0) begin
         rot_in.x = src.x - (src.y >>> STEP);
         rot_in.y = src.y + (src.x >>> STEP);
         rot_in.z = src.z - ATAN;
      end else begin
         rot_in.x = src.x + (src.y >>> STEP);
         rot_in.y = src.y - (src.x >>> STEP);
         rot_in.z = src.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff <= rot_in;
      end
   end

endmodule

// ===== rtl/planar_heading_to_quaternion.sv =====
// Pipeline: 2*N+4 register stages, N = CORDIC_STEPS capped at 24.
// Throughput: one request per cycle while the skid buffer is empty; each CORDIC stage
// does one iteration, the vectoring stages first and the rotating ones after, with a
// one-entry skid buffer at the output. A held response stalls the whole pipeline from
// the cycle after it first waits. Reset (synchronous) clears all valid bits and the
// skid buffer's valid flag.
`timescale 1ns / 1ps
module planar_heading_to_quaternion import pqt_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   pqt_req_if.sink     req_chan,
   pqt_rsp_if.source   rsp_chan
);

   localparam int NSTEP  = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
   localparam int NST    = 2 * NSTEP + 4;
   localparam int S_OUT  = NST - 1;

   function automatic logic signed [31:0] sat_diff(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   logic               en;
   logic [NST-1:0]     valid_ff;
   pos_type            pos_ff [NST-1];
   logic signed [31:0] dx_ff, dy_ff;
   vec_type            prep_in, prep_ff;
   vec_type            vec_d [NSTEP+1];
   rot_type            head_in, head_ff;
   rot_type            rot_d [NSTEP+1];
   out_type            out_in, out_ff;
   out_type            skid_ff;
   logic               skid_valid_ff;

   assign en = !skid_valid_ff;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-2:0], req_chan.valid};
      end
   end

   // Position rides alongside the arithmetic.
   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= '{x: req_chan.center_x, y: req_chan.center_y, z: req_chan.center_z};
         for (int k = 1; k < NST - 1; k++) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // Differences, saturated to 32 bits.
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= sat_diff(33'(req_chan.axis_tip_x) - 33'(req_chan.center_x));
         dy_ff <= sat_diff(33'(req_chan.axis_tip_y) - 33'(req_chan.center_y));
      end
   end

   // Axis cases give exact headings; a left-half vector is turned by pi first.
   always_comb begin
      prep_in.special    = (dy_ff == 0) || (dx_ff == 0);
      prep_in.fixed_head = HEAD_EAST;
      if (dy_ff == 0) begin
         prep_in.fixed_head = (dx_ff < 0) ? HEAD_WEST : HEAD_EAST;
      end else if (dx_ff == 0) begin
         prep_in.fixed_head = (dy_ff > 0) ? HEAD_NORTH : HEAD_SOUTH;
      end
      if (dx_ff < 0) begin
         prep_in.x = -VEC_W'(dx_ff);
         prep_in.y = -VEC_W'(dy_ff);
         prep_in.z = 32'h8000_0000;
      end else begin
         prep_in.x = VEC_W'(dx_ff);
         prep_in.y = VEC_W'(dy_ff);
         prep_in.z = 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign vec_d[0] = prep_ff;

   for (genvar k = 0; k < NSTEP; k++) begin : g_vec
      pqt_vec_stage #(.STEP(k)) u_vec (
         .clock  (clock),
         .en     (en),
         .src    (vec_d[k]),
         .vec_ff (vec_d[k+1])
      );
   end

   // Round the heading, then halve it; the upper half-turn is folded by 90 degrees.
   logic [31:0] head_round;
   logic [15:0] head_val;

   always_comb begin
      head_round    = vec_d[NSTEP].z + 32'h8000;
      head_val      = vec_d[NSTEP].special ? vec_d[NSTEP].fixed_head : head_round[31:16];
      head_in.upper = head_val[15];
      head_in.head  = head_val;
      head_in.x     = CORDIC_X0;
      head_in.y     = '0;
      head_in.z     = $signed({3'b000, head_val[14:0], 15'b0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff <= head_in;
      end
   end

   assign rot_d[0] = head_ff;

   for (genvar k = 0; k < NSTEP; k++) begin : g_rot
      pqt_rot_stage #(.STEP(k)) u_rot (
         .clock  (clock),
         .en     (en),
         .src    (rot_d[k]),
         .rot_ff (rot_d[k+1])
      );
   end

   // Undo the fold, round to Q1.15 and clamp.
   logic signed [ROT_W-1:0] cos_v, sin_v, cos_q, sin_q;

   always_comb begin
      cos_v = rot_d[NSTEP].upper ? -rot_d[NSTEP].y : rot_d[NSTEP].x;
      sin_v = rot_d[NSTEP].upper ? rot_d[NSTEP].x : rot_d[NSTEP].y;
      cos_q = (cos_v + 33'sd16384) >>> 15;
      sin_q = (sin_v + 33'sd16384) >>> 15;
      out_in.pos  = pos_ff[NST-2];
      out_in.head = rot_d[NSTEP].head;
      if (sin_q < 0) begin
         out_in.qz = '0;
      end else if (sin_q > 33'sd32767) begin
         out_in.qz = 15'h7FFF;
      end else begin
         out_in.qz = sin_q[14:0];
      end
      if (cos_q > 33'sd32767) begin
         out_in.qw = 16'sh7FFF;
      end else if (cos_q < -33'sd32768) begin
         out_in.qw = 16'sh8000;
      end else begin
         out_in.qw = cos_q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   // A response not taken moves into the skid buffer, which then holds the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (valid_ff[S_OUT] && !rsp_chan.ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_ff <= out_ff;
      end
   end

   out_type rsp_data;

   assign rsp_data             = skid_valid_ff ? skid_ff : out_ff;
   assign rsp_chan.valid       = skid_valid_ff || valid_ff[S_OUT];
   assign rsp_chan.pos_x       = rsp_data.pos.x;
   assign rsp_chan.pos_y       = rsp_data.pos.y;
   assign rsp_chan.pos_z       = rsp_data.pos.z;
   assign rsp_chan.heading     = rsp_data.head;
   assign rsp_chan.quat_z_part = rsp_data.qz;
   assign rsp_chan.quat_w_part = rsp_data.qw;

endmodule
